// ===== rtl/cpa_pkg.sv =====
package cpa_pkg;

  // Pool geometry
  localparam int MAX_CHUNKS   = 1024;
  localparam int CHUNK_BYTES  = 2048;  // power of two: rounding and capacity use shifts
  localparam int HEADER_BYTES = 64;

  // Fixed field widths
  localparam int MODE_W    = 1;
  localparam int PAYLOAD_W = 16;
  localparam int FREE_W    = 10;
  localparam int PAD_W     = 8;
  localparam int COUNT_W   = 11;
  localparam int START_W   = 10;
  localparam int RUN_W     = 8;
  localparam int CAP_W     = 19;
  localparam int USED_W    = 11;

  // Derived internal widths
  localparam int IDX_W     = $clog2(MAX_CHUNKS);
  localparam int CNT_W     = $clog2(MAX_CHUNKS + 1);
  localparam int POS_W     = $clog2(MAX_CHUNKS + 2 * (2 ** RUN_W));
  localparam int RUN_MAX   = (2 ** RUN_W) - 1;
  localparam int CB_SH     = $clog2(CHUNK_BYTES);
  localparam int BYTES_MAX = HEADER_BYTES + 2 * ((2 ** PAD_W) - 1)
                           + ((2 ** PAYLOAD_W) - 1) + CHUNK_BYTES - 1;
  localparam int BYTES_W   = $clog2(BYTES_MAX + 1);
  localparam int REQ_W     = BYTES_W - CB_SH;
  localparam int CAPF_W    = RUN_W + CB_SH;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_PADDING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_PADDING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT  = 2'd2;

  // Datapath commands
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_LOAD,
    OP_CALC,
    OP_PART2,
    OP_READ,
    OP_CHECK,
    OP_MARK,
    OP_FREE_CHECK,
    OP_CLEAR,
    OP_COMMIT_ALLOC,
    OP_COMMIT_FREE,
    OP_FAIL
  } dp_op_e;

  // Datapath status toward the controller
  typedef struct packed {
    logic init_last;
    logic is_free;
    logic req_ok;
    logic idx_ok;
    logic cand_ok;
    logic in_part2;
    logic hit;
    logic j_last;
    logic free_fit;
  } dp_status_t;

  // One result beat
  typedef struct packed {
    logic                 success;
    logic [START_W-1:0]   start_chunk;
    logic [RUN_W-1:0]     run_chunks;
    logic [CAP_W-1:0]     capacity_bytes;
    logic [USED_W-1:0]    chunks_in_use;
  } res_t;

endpackage

// ===== rtl/chunk_pool_next_fit_allocator_top.sv =====
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: mode; tdata: payload_bytes,
//                                                    free_chunk
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser: success; tdata: start_chunk,
//                                                    run_chunks, capacity_bytes,
//                                                    chunks_in_use
// cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One item at a time. An allocate takes and sizes the request, probes run map entries
// for each candidate start checked (wrapping once to the head of the pool), marks each
// chunk of the run, then commits or fails and hands off. A free reads and checks the
// map entry of the freed chunk, clears each chunk of its run, then commits or fails.
// The single-port run map, read one entry per probe, sets the search time.
// After reset a clearing pass writes all 1024 map entries, one per cycle; no input
// beat is taken until it ends, while configuration writes are taken at any time.
// The result register lets the next input beat be taken while a result waits; a
// finished item then holds until that register drains.
module chunk_pool_next_fit_allocator_top import cpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // [15:0] payload_bytes, [25:16] free_chunk
  input  logic [0:0]           s_axis_tuser,   // [0] mode
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,   // [9:0] start_chunk, [17:10] run_chunks,
                                               // [36:18] capacity_bytes,
                                               // [47:37] chunks_in_use
  output logic [0:0]           m_axis_tuser,   // [0] success
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COUNT_W-1:0]   cfg_data_i
);

  logic [PAD_W-1:0]   head_q, head_d;
  logic [PAD_W-1:0]   tail_q, tail_d;
  logic [COUNT_W-1:0] count_q, count_d;

  logic       m_valid_q, m_valid_d;
  res_t       m_res_q, m_res_d;

  dp_op_e     op;
  dp_status_t status;
  res_t       dp_res;
  logic       push;
  logic       out_free;

  // Registers are always writable; write them only while no item is in flight.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEAD_PADDING: head_d  = cfg_data_i[PAD_W-1:0];
        CFG_TAIL_PADDING: tail_d  = cfg_data_i[PAD_W-1:0];
        CFG_CHUNK_COUNT:  count_d = cfg_data_i;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Result register: free when empty or draining in this cycle.
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_res_d   = m_res_q;
    if (push) begin
      m_valid_d = 1'b1;
      m_res_d   = dp_res;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= COUNT_W'(MAX_CHUNKS);
      m_valid_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Result payload holds until the next push.
  always_ff @(posedge clk_i) begin
    m_res_q <= m_res_d;
  end

  cpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .push_o     (push),
    .status_i   (status),
    .op_o       (op)
  );

  cpa_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_head_i   (head_q),
    .cfg_tail_i   (tail_q),
    .cfg_count_i  (count_q),
    .in_mode_i    (s_axis_tuser),
    .in_payload_i (s_axis_tdata[15:0]),
    .in_free_i    (s_axis_tdata[25:16]),
    .op_i         (op),
    .status_o     (status),
    .res_o        (dp_res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.success;
  assign m_axis_tdata  = {m_res_q.chunks_in_use, m_res_q.capacity_bytes,
                          m_res_q.run_chunks, m_res_q.start_chunk};

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && m_valid_q |-> m_axis_tready)
    else $error("result overwrote a beat not yet taken");

endmodule

// ===== rtl/cpa_ctrl.sv =====
module cpa_ctrl import cpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_free_i,
  output logic       push_o,
  input  dp_status_t status_i,
  output dp_op_e     op_o
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CALC,
    ST_ROUTE,
    ST_COND,
    ST_READ,
    ST_CHECK,
    ST_MARK,
    ST_COMMIT_A,
    ST_FREE_READ,
    ST_FREE_CHECK,
    ST_CLEAR,
    ST_COMMIT_F,
    ST_FAIL,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NOP;
    push_o  = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        op_o = OP_INIT;
        if (status_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        op_o    = OP_CALC;
        state_d = ST_ROUTE;
      end
      ST_ROUTE: begin
        if (status_i.is_free) begin
          state_d = status_i.idx_ok ? ST_FREE_READ : ST_FAIL;
        end else begin
          state_d = status_i.req_ok ? ST_COND : ST_FAIL;
        end
      end
      ST_COND: begin
        if (status_i.cand_ok) begin
          state_d = ST_READ;
        end else if (!status_i.in_part2) begin
          op_o = OP_PART2;  // wrap to the head of the pool
        end else begin
          state_d = ST_FAIL;
        end
      end
      ST_READ: begin
        op_o    = OP_READ;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        op_o = OP_CHECK;
        if (status_i.hit && status_i.j_last) state_d = ST_MARK;
        else if (status_i.hit)               state_d = ST_READ;
        else                                 state_d = ST_COND;
      end
      ST_MARK: begin
        op_o = OP_MARK;
        if (status_i.j_last) state_d = ST_COMMIT_A;
      end
      ST_COMMIT_A: begin
        op_o    = OP_COMMIT_ALLOC;
        state_d = ST_DONE;
      end
      ST_FREE_READ: begin
        op_o    = OP_READ;
        state_d = ST_FREE_CHECK;
      end
      ST_FREE_CHECK: begin
        if (status_i.free_fit) begin
          op_o    = OP_FREE_CHECK;
          state_d = status_i.hit ? ST_COMMIT_F : ST_CLEAR;
        end else begin
          state_d = ST_FAIL;
        end
      end
      ST_CLEAR: begin
        op_o = OP_CLEAR;
        if (status_i.j_last) state_d = ST_COMMIT_F;
      end
      ST_COMMIT_F: begin
        op_o    = OP_COMMIT_FREE;
        state_d = ST_DONE;
      end
      ST_FAIL: begin
        op_o    = OP_FAIL;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_init_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_INIT |=> state_q != ST_INIT)
    else $error("clearing pass re-entered");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && in_valid_i |=> state_q == ST_CALC)
    else $error("accepted beat did not start an item");

endmodule

// ===== rtl/cpa_datapath.sv =====
module cpa_datapath import cpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [PAD_W-1:0]     cfg_head_i,
  input  logic [PAD_W-1:0]     cfg_tail_i,
  input  logic [COUNT_W-1:0]   cfg_count_i,
  input  logic [MODE_W-1:0]    in_mode_i,
  input  logic [PAYLOAD_W-1:0] in_payload_i,
  input  logic [FREE_W-1:0]    in_free_i,
  input  dp_op_e               op_i,
  output dp_status_t           status_o,
  output res_t                 res_o
);

  // Run map: one entry per chunk, chunks left in its run, zero when free
  logic [RUN_W-1:0] map_mem [MAX_CHUNKS];

  logic [POS_W-1:0]     s_q, s_d;
  logic [CNT_W-1:0]     next_pos_q, next_pos_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [RUN_W-1:0]     j_q, j_d;
  logic [RUN_W-1:0]     req_q, req_d;
  logic                 req_ok_q, req_ok_d;
  logic                 part2_q, part2_d;
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [PAYLOAD_W-1:0] payload_q, payload_d;
  logic [FREE_W-1:0]    free_q, free_d;
  res_t                 res_q, res_d;
  logic [RUN_W-1:0]     rd_q;

  logic [CNT_W-1:0]   count_eff;
  logic [CNT_W-1:0]   lim;
  logic [BYTES_W-1:0] bytes_up;
  logic [REQ_W-1:0]   req_full;
  logic [CAPF_W-1:0]  cap_full;
  logic [IDX_W-1:0]   addr;
  logic               wr_en;
  logic [RUN_W-1:0]   wr_data;
  logic               cand1;

  assign count_eff = (32'(cfg_count_i) > MAX_CHUNKS) ? CNT_W'(MAX_CHUNKS)
                                                    : CNT_W'(cfg_count_i);
  assign lim       = count_eff - CNT_W'(req_q);

  assign bytes_up = BYTES_W'(HEADER_BYTES) + BYTES_W'(cfg_head_i) + BYTES_W'(payload_q)
                  + BYTES_W'(cfg_tail_i) + BYTES_W'(CHUNK_BYTES - 1);
  assign req_full = REQ_W'(bytes_up >> CB_SH);
  assign cap_full = {req_q, {CB_SH{1'b0}}} - CAPF_W'(HEADER_BYTES);

  assign addr = (op_i == OP_INIT) ? IDX_W'(s_q) : IDX_W'(s_q + POS_W'(j_q));

  assign cand1 = POS_W'(lim) >= s_q;

  always_comb begin
    status_o.init_last = (IDX_W'(s_q) == IDX_W'(MAX_CHUNKS - 1));
    status_o.is_free   = mode_q[0];
    status_o.req_ok    = req_ok_q;
    status_o.idx_ok    = CNT_W'(free_q) < count_eff;
    status_o.in_part2  = part2_q;
    status_o.cand_ok   = part2_q ? (cand1 && (s_q + POS_W'(req_q) < POS_W'(next_pos_q)))
                                 : cand1;
    status_o.hit       = (rd_q == '0);
    status_o.j_last    = (j_q + RUN_W'(1) == req_q);
    status_o.free_fit  = (s_q + POS_W'(rd_q)) <= POS_W'(count_eff);
  end

  always_comb begin
    s_d        = s_q;
    next_pos_d = next_pos_q;
    used_d     = used_q;
    j_d        = j_q;
    req_d      = req_q;
    req_ok_d   = req_ok_q;
    part2_d    = part2_q;
    mode_d     = mode_q;
    payload_d  = payload_q;
    free_d     = free_q;
    res_d      = res_q;
    wr_en      = 1'b0;
    wr_data    = '0;
    case (op_i)
      OP_INIT: begin
        wr_en = 1'b1;
        s_d   = s_q + POS_W'(1);
      end
      OP_LOAD: begin
        mode_d    = in_mode_i;
        payload_d = in_payload_i;
        free_d    = in_free_i;
      end
      OP_CALC: begin
        req_d    = RUN_W'(req_full);
        req_ok_d = (req_full != '0) && (32'(req_full) <= RUN_MAX)
                   && (32'(req_full) <= 32'(count_eff));
        s_d      = mode_q[0] ? POS_W'(free_q) : POS_W'(next_pos_q);
        j_d      = '0;
        part2_d  = 1'b0;
      end
      OP_PART2: begin
        s_d     = '0;
        j_d     = '0;
        part2_d = 1'b1;
      end
      OP_CHECK: begin
        if (rd_q == '0) begin
          j_d = (j_q + RUN_W'(1) == req_q) ? '0 : j_q + RUN_W'(1);
        end else begin
          // skip past the end of the busy run
          s_d = s_q + POS_W'(j_q) + POS_W'(rd_q);
          j_d = '0;
        end
      end
      OP_MARK: begin
        wr_en   = 1'b1;
        wr_data = req_q - j_q;
        j_d     = j_q + RUN_W'(1);
      end
      OP_FREE_CHECK: begin
        req_d = rd_q;
        j_d   = '0;
      end
      OP_CLEAR: begin
        wr_en = 1'b1;
        j_d   = j_q + RUN_W'(1);
      end
      OP_COMMIT_ALLOC: begin
        next_pos_d = CNT_W'(s_q + POS_W'(req_q));
        used_d     = used_q + CNT_W'(req_q);
        res_d.success        = 1'b1;
        res_d.start_chunk    = START_W'(s_q);
        res_d.run_chunks     = req_q;
        res_d.capacity_bytes = CAP_W'(cap_full);
        res_d.chunks_in_use  = USED_W'(used_d);
      end
      OP_COMMIT_FREE: begin
        used_d = (used_q >= CNT_W'(req_q)) ? used_q - CNT_W'(req_q) : '0;
        res_d.success        = 1'b1;
        res_d.start_chunk    = '0;
        res_d.run_chunks     = req_q;
        res_d.capacity_bytes = '0;
        res_d.chunks_in_use  = USED_W'(used_d);
      end
      OP_FAIL: begin
        res_d.success        = 1'b0;
        res_d.start_chunk    = '0;
        res_d.run_chunks     = '0;
        res_d.capacity_bytes = '0;
        res_d.chunks_in_use  = USED_W'(used_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q        <= '0;
      next_pos_q <= '0;
      used_q     <= '0;
    end else begin
      s_q        <= s_d;
      next_pos_q <= next_pos_d;
      used_q     <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q       <= j_d;
    req_q     <= req_d;
    req_ok_q  <= req_ok_d;
    part2_q   <= part2_d;
    mode_q    <= mode_d;
    payload_q <= payload_d;
    free_q    <= free_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) map_mem[addr] <= wr_data;
    if (op_i == OP_READ) rd_q <= map_mem[addr];
  end

  assign res_o = res_q;

  a_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_MARK || op_i == OP_CLEAR) |-> j_q < req_q)
    else $error("map write past the end of the run");

  a_grant_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_COMMIT_ALLOC |=> res_q.success && res_q.run_chunks != '0
      && next_pos_q == CNT_W'(res_q.start_chunk) + CNT_W'(res_q.run_chunks))
    else $error("search position does not follow the granted run");

endmodule
